### hw/rtl/elpc_pkg.sv
// Shared types, character constants and verdict codes for the local-part checker.
`timescale 1ns / 1ps

package elpc_pkg;

  // Verdict codes
  localparam logic [3:0] VERDICT_OK         = 4'd0;
  localparam logic [3:0] VERDICT_EMPTY      = 4'd1;
  localparam logic [3:0] VERDICT_NON_ASCII  = 4'd2;
  localparam logic [3:0] VERDICT_CONTROL    = 4'd3;
  localparam logic [3:0] VERDICT_BAD_QUOTE  = 4'd4;
  localparam logic [3:0] VERDICT_DOTS       = 4'd5;
  localparam logic [3:0] VERDICT_SPECIAL    = 4'd6;
  localparam logic [3:0] VERDICT_WHITESPACE = 4'd7;
  localparam logic [3:0] VERDICT_OPEN_QUOTE = 4'd8;
  localparam logic [3:0] VERDICT_MAX        = VERDICT_OPEN_QUOTE;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  typedef struct packed {
    logic       in_quote;
    logic       in_pair;
    logic [7:0] previous_byte;
    logic       at_start;
    logic       dot_pending;
    logic       space_pending;
    logic       stopped_on_nul;
    logic [3:0] first_error;
  } scan_state_t;

  localparam scan_state_t SCAN_STATE_RESET = '{
    in_quote:       1'b0,
    in_pair:        1'b0,
    previous_byte:  CH_NUL,
    at_start:       1'b1,
    dot_pending:    1'b0,
    space_pending:  1'b0,
    stopped_on_nul: 1'b0,
    first_error:    VERDICT_OK
  };

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    logic hit;
    begin
      unique case (c)
        8'h28, 8'h29, 8'h3C, 8'h3E, CH_AT,
        8'h2C, 8'h3B, 8'h3A, CH_BSLASH,
        8'h5B, 8'h5D, CH_SPACE: hit = 1'b1;
        default:                hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

endpackage

### hw/rtl/elpc_scan.sv
// One-byte scan step: next scanner state and verdict for one request.
`timescale 1ns / 1ps

module elpc_scan (
  input  elpc_pkg::scan_state_t cur,
  input  logic [7:0]            char_code,
  input  logic                  has_char,
  input  logic                  last_char,
  output elpc_pkg::scan_state_t nxt,
  output logic [3:0]            verdict
);
  import elpc_pkg::*;

  scan_state_t s;
  logic        stop;

  always_comb begin
    s    = cur;
    stop = 1'b0;
    if (has_char) begin
      if ((cur.first_error == VERDICT_OK) && !cur.stopped_on_nul) begin
        // settle lookahead checks left by the previous byte
        if (s.dot_pending) begin
          s.dot_pending = 1'b0;
          if (char_code == CH_DOT) begin
            s.first_error = VERDICT_DOTS;
            stop          = 1'b1;
          end
        end
        if (!stop && s.space_pending) begin
          s.space_pending = 1'b0;
          if (!((char_code == CH_QUOTE) || is_ws(char_code))) begin
            s.first_error = VERDICT_WHITESPACE;
            stop          = 1'b1;
          end
        end
        if (!stop) begin
          if (char_code == CH_NUL) begin
            s.stopped_on_nul = 1'b1;
          end else if (char_code[7]) begin
            s.first_error = VERDICT_NON_ASCII;
          end else if (((char_code < CH_SPACE) || (char_code == CH_DEL)) && !cur.in_quote) begin
            s.first_error = VERDICT_CONTROL;
          end else begin
            if (!cur.in_quote) begin
              if (char_code == CH_QUOTE) begin
                if (cur.at_start || (cur.previous_byte == CH_DOT)) begin
                  s.in_quote = 1'b1;
                end else begin
                  s.first_error = VERDICT_BAD_QUOTE;
                  stop          = 1'b1;
                end
              end else if (char_code == CH_DOT) begin
                if (cur.at_start) begin
                  s.first_error = VERDICT_DOTS;
                  stop          = 1'b1;
                end else if (!last_char) begin
                  s.dot_pending = 1'b1;
                end
              end else if (is_special(char_code)) begin
                s.first_error = VERDICT_SPECIAL;
                stop          = 1'b1;
              end
            end else if (cur.in_pair) begin
              s.in_pair = 1'b0;
            end else if (char_code == CH_QUOTE) begin
              s.in_quote = 1'b0;
            end else if (char_code == CH_BSLASH) begin
              s.in_pair = 1'b1;
            end else if (is_ws(char_code)) begin
              if (!((cur.previous_byte == CH_QUOTE) || is_ws(cur.previous_byte)) &&
                  !last_char) begin
                s.space_pending = 1'b1;
              end
            end
            if (!stop) begin
              s.previous_byte = char_code;
            end
          end
        end
      end
      s.at_start = 1'b0;
    end

    priority if (s.first_error != VERDICT_OK) begin
      verdict = s.first_error;
    end else if (s.at_start) begin
      verdict = VERDICT_EMPTY;
    end else if (s.in_quote) begin
      verdict = VERDICT_OPEN_QUOTE;
    end else begin
      verdict = VERDICT_OK;
    end

    // a verdict closes the local part: start clean for the next one
    nxt = last_char ? SCAN_STATE_RESET : s;
  end

endmodule

### hw/rtl/email_local_part_checker.sv
// Top level of the streaming e-mail local-part checker.
`timescale 1ns / 1ps
//
//  Channel | Dir | Signals                                   | Content
//  --------+-----+-------------------------------------------+-------------------------------
//  s       | in  | s_tvalid s_tready s_tdata s_tuser s_tlast | char_code, has_char, last_char
//  m       | out | m_tvalid m_tready m_tdata                 | tdata[3:0] verdict, [7:4] zero
//
//  One byte request per cycle, sustained while s_tready stays high. A request is captured
//  in the input register and scanned from there; a verdict (only for a request with tlast)
//  lands in the output register when that request advances out of the input register.
//  Synchronous rst restarts the scanner on a fresh local part and empties both registers.
//  s_tready drops only while a last request waits behind an unaccepted verdict;
//  non-last requests never wait on m_tready.

module email_local_part_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tuser,   // [0] has_char
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [3:0] verdict, [7:4] zero
);
  import elpc_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_has;
  logic       in_last;

  // scanner state and result register
  scan_state_t state;
  scan_state_t state_next;
  logic [3:0]  verdict_next;
  logic [3:0]  verdict;
  logic        out_valid;

  logic advance;

  // A held request moves on unless it carries a verdict and the output is full and not taken.
  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  elpc_scan u_scan (
    .cur       (state),
    .char_code (in_char),
    .has_char  (in_has),
    .last_char (in_last),
    .nxt       (state_next),
    .verdict   (verdict_next)
  );

  // capture the request; payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_has  <= s_tuser;
      in_last <= s_tlast;
    end
  end

  // advance the scanner state once per consumed request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // hold the verdict until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      verdict <= verdict_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, verdict};

endmodule

### hw/rtl/elpc_sva.sv
// Port-level checker for the local-part checker, bound to the top level.
`timescale 1ns / 1ps

module elpc_sva (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import elpc_pkg::*;

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("verdict changed or dropped while stalled");

  // verdict is a defined code with clear padding
  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] <= VERDICT_MAX) && (m_tdata[7:4] == 4'b0000))
    else $error("verdict out of range");

  // input side stalls only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

  // no verdict right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("verdict present right after reset");

endmodule

bind email_local_part_checker elpc_sva u_elpc_sva (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/elpc_verdict_checker.sv
// Scoreboard for the local-part checker: predicts verdicts and compares them with the output stream.
`timescale 1ns / 1ps

module elpc_verdict_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tuser,   // [0] has_char
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [3:0] verdict, [7:4] zero
  output int         mismatches,
  output int         verdicts_owed
);

  import elpc_pkg::*;

  // Scanner state of the local part in flight
  logic       quoted;
  logic       pair_open;
  logic [7:0] prior_char;
  logic       fresh;
  logic       dot_wait;
  logic       ws_wait;
  logic       nul_seen;
  logic [3:0] err_code;

  logic [3:0] verdict_q[$];
  logic [3:0] want;
  logic [3:0] got;
  int         bad_count = 0;
  int         owed_count = 0;

  assign mismatches    = bad_count;
  assign verdicts_owed = owed_count;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    bad_count++;
  endtask

  function automatic logic blank_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // Characters that must be quoted: ( ) < > @ , ; : \ [ ] and space
  function automatic logic reserved_char(input logic [7:0] c);
    logic hit;
    case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, CH_AT, 8'h2C, 8'h3B, 8'h3A,
      CH_BSLASH, 8'h5B, 8'h5D, CH_SPACE: hit = 1'b1;
      default:                           hit = 1'b0;
    endcase
    return hit;
  endfunction

  task automatic clear_scan();
    quoted     = 1'b0;
    pair_open  = 1'b0;
    prior_char = CH_NUL;
    fresh      = 1'b1;
    dot_wait   = 1'b0;
    ws_wait    = 1'b0;
    nul_seen   = 1'b0;
    err_code   = VERDICT_OK;
  endtask

  // Advance the scanner by one byte; fin marks the final byte.
  task automatic scan_char(input logic [7:0] c, input logic fin);
    // Settle lookahead checks left by the previous byte first.
    if (dot_wait) begin
      dot_wait = 1'b0;
      if (c == CH_DOT) begin
        err_code = VERDICT_DOTS;
        return;
      end
    end
    if (ws_wait) begin
      ws_wait = 1'b0;
      if (!(c == CH_QUOTE || blank_char(c))) begin
        err_code = VERDICT_WHITESPACE;
        return;
      end
    end
    if (c == CH_NUL) begin
      nul_seen = 1'b1;
      return;
    end
    if (c[7]) begin
      err_code = VERDICT_NON_ASCII;
      return;
    end
    if ((c < CH_SPACE || c == CH_DEL) && !quoted) begin
      err_code = VERDICT_CONTROL;
      return;
    end
    if (!quoted) begin
      if (c == CH_QUOTE) begin
        if (fresh || prior_char == CH_DOT) begin
          quoted = 1'b1;
        end else begin
          err_code = VERDICT_BAD_QUOTE;
          return;
        end
      end else if (c == CH_DOT) begin
        if (fresh) begin
          err_code = VERDICT_DOTS;
          return;
        end
        if (!fin) dot_wait = 1'b1;
      end else if (reserved_char(c)) begin
        err_code = VERDICT_SPECIAL;
        return;
      end
    end else if (pair_open) begin
      pair_open = 1'b0;
    end else if (c == CH_QUOTE) begin
      quoted = 1'b0;
    end else if (c == CH_BSLASH) begin
      pair_open = 1'b1;
    end else if (blank_char(c)) begin
      if (!(prior_char == CH_QUOTE || blank_char(prior_char)) && !fin) ws_wait = 1'b1;
    end
    prior_char = c;
  endtask

  initial clear_scan();

  always @(posedge clk) begin
    if (!rst) begin
      // Retire first: a verdict leaving now belongs to an older request.
      if (m_tvalid && m_tready) begin
        got = m_tdata[3:0];
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with no local part pending", got));
        end else begin
          want = verdict_q.pop_front();
          if (got !== want)
            report_mismatch($sformatf("verdict %0d, expected %0d", got, want));
          if (m_tdata[7:4] !== 4'd0)
            report_mismatch($sformatf("tdata upper bits %b, expected zero", m_tdata[7:4]));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          if (err_code == VERDICT_OK && !nul_seen) scan_char(s_tdata, s_tlast);
          fresh = 1'b0;
        end
        if (s_tlast) begin
          if (err_code != VERDICT_OK) want = err_code;
          else if (fresh)             want = VERDICT_EMPTY;
          else if (quoted)            want = VERDICT_OPEN_QUOTE;
          else                        want = VERDICT_OK;
          verdict_q.push_back(want);
          clear_scan();
        end
      end
      owed_count = verdict_q.size();
    end
  end

endmodule

### tb/email_local_part_checker_tb.sv
// Testbench top for the local-part checker: stimulus, handshake pacing and final verdict.
`timescale 1ns / 1ps

module email_local_part_checker_tb;

  import elpc_pkg::*;

  localparam int IDLE_PCT     = 27;
  localparam int HOLD_CYCLES  = 150;
  localparam int RUN_LIMIT_NS = 400000;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] char_code
  logic       s_tuser;   // [0] has_char
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [3:0] verdict, [7:4] zero

  int         fails;
  int         owed;
  int         items_sent = 0;
  logic       steady = 1'b0;     // no idling on either side while set
  logic       hold_req = 1'b0;   // ask the receiver for a long hold-off
  logic [7:0] word[$];           // local part being sent

  email_local_part_checker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  elpc_verdict_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatches    (fails),
    .verdicts_owed (owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost verdict ends here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  // Verdict receiver. Drop tready at random, or hold it low for a long
  // stretch on request so the block backs up into its input.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Characters allowed bare in an atom: letters, digits and a few symbols
  function automatic logic [7:0] atext_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = 8'($urandom_range(8'h61, 8'h7A));
      1: c = 8'($urandom_range(8'h41, 8'h5A));
      2: c = 8'($urandom_range(8'h30, 8'h39));
      default: begin
        case ($urandom_range(0, 18))
          0:  c = 8'h21;
          1:  c = 8'h23;
          2:  c = 8'h24;
          3:  c = 8'h25;
          4:  c = 8'h26;
          5:  c = 8'h27;
          6:  c = 8'h2A;
          7:  c = 8'h2B;
          8:  c = 8'h2D;
          9:  c = 8'h2F;
          10: c = 8'h3D;
          11: c = 8'h3F;
          12: c = 8'h5E;
          13: c = 8'h5F;
          14: c = 8'h60;
          15: c = 8'h7B;
          16: c = 8'h7C;
          17: c = 8'h7D;
          default: c = 8'h7E;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ws_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = CH_SPACE;
      1:       c = CH_TAB;
      2:       c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

  // Printable byte inside quotes, neither a quote nor a backslash
  function automatic logic [7:0] qtext_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'h7E));
    if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h71;
    return c;
  endfunction

  // Bytes that hit the error paths and the corners of the scanner
  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0:       c = CH_NUL;
      1:       c = CH_DOT;
      2:       c = CH_QUOTE;
      3:       c = CH_SPACE;
      4:       c = CH_BSLASH;
      5:       c = CH_AT;
      6:       c = CH_DEL;
      7:       c = 8'($urandom_range(8'h80, 8'hFF));
      8:       c = 8'($urandom_range(8'h01, 8'h1F));
      9:       c = CH_TAB;
      10:      c = CH_CR;
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // Offer one request and hold it until accepted. Starts and ends on a
  // falling edge; idle cycles are inserted up front unless steady is set.
  task automatic send_req(input logic [7:0] c, input logic has, input logic fin);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= has;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (has || fin) items_sent++;
    @(negedge clk);
  endtask

  // Send the bytes of word. With end_mark, close with a request that
  // carries no byte; an empty word always closes that way.
  task automatic send_word(input logic end_mark);
    int i;
    for (i = 0; i < word.size(); i++) begin
      // Occasionally slip in a request with no byte and no end mark.
      if ($urandom_range(0, 19) == 0) send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_req(word[i], 1'b1, !end_mark && (i == word.size() - 1));
    end
    if (end_mark || word.size() == 0) send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Build a random local part: mostly well-formed atoms and quoted strings
  // joined by dots, some with one corrupted byte; the rest is raw noise.
  task automatic build_word();
    int kind;
    int nseg;
    int s;
    int n;
    int k;
    word.delete();
    kind = $urandom_range(0, 99);
    if (kind < 2) return;
    if (kind < 67) begin
      nseg = $urandom_range(1, 3);
      for (s = 0; s < nseg; s++) begin
        if (s > 0) word.push_back(CH_DOT);
        if ($urandom_range(0, 3) == 0) begin
          word.push_back(CH_QUOTE);
          n = $urandom_range(0, 5);
          for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
              0: begin
                word.push_back(CH_BSLASH);
                word.push_back(8'($urandom_range(1, 127)));
              end
              1: begin
                word.push_back(ws_char());
                if ($urandom_range(0, 1)) word.push_back(ws_char());
              end
              default: word.push_back(qtext_char());
            endcase
          end
          // Leave the quote open now and then.
          if ($urandom_range(0, 7) != 0) word.push_back(CH_QUOTE);
        end else begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) word.push_back(atext_char());
        end
      end
      if ($urandom_range(0, 3) == 0) word[$urandom_range(0, word.size() - 1)] = odd_char();
    end else if (kind < 87) begin
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) word.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) word.push_back(odd_char());
    end
  endtask

  task automatic run_random(input int goal);
    while (items_sent < goal) begin
      build_word();
      send_word($urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners, one verdict each
    word.delete();                                     send_word(1'b0); // empty
    word = '{CH_NUL};                                  send_word(1'b0); // NUL first
    word = '{8'hFF};                                   send_word(1'b0); // non-ASCII
    word = '{8'h01};                                   send_word(1'b0); // control
    word = '{CH_DEL};                                  send_word(1'b0); // DEL
    word = '{8'h61, CH_QUOTE};                         send_word(1'b0); // quote mid-atom
    word = '{CH_DOT};                                  send_word(1'b0); // leading dot
    word = '{8'h61, CH_DOT, CH_DOT};                   send_word(1'b0); // doubled dot
    word = '{CH_AT};                                   send_word(1'b0); // special
    word = '{CH_QUOTE, 8'h61, CH_SPACE, 8'h62};        send_word(1'b0); // stray space
    word = '{CH_QUOTE, CH_BSLASH, 8'h01, CH_QUOTE};    send_word(1'b0); // quoted pair
    word = '{CH_QUOTE};                                send_word(1'b0); // open quote
    send_req(8'h00, 1'b0, 1'b0);                                        // no byte
    word = '{8'h61};                                   send_word(1'b1); // end without byte

    run_random(450);

    // Back-to-back stretch with no idling on either side
    steady = 1'b1;
    run_random(750);
    steady = 1'b0;

    // Receiver stalls while short local parts keep coming: fills the
    // output path and forces tready low on the input.
    hold_req = 1'b1;
    repeat (40) begin
      word.delete();
      word.push_back(atext_char());
      if ($urandom_range(0, 1)) word.push_back(atext_char());
      send_word(1'b0);
    end

    run_random(1250);
    s_tvalid <= 1'b0;

    // Drain: every verdict retired, then wait for stragglers.
    wait (owed == 0);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/elpc_pkg.sv
hw/rtl/elpc_scan.sv
hw/rtl/email_local_part_checker.sv
hw/rtl/elpc_sva.sv
tb/elpc_verdict_checker.sv
tb/email_local_part_checker_tb.sv
